FILE: rtl/core/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants for the linear system solver
// Sequencer state codes and the saturated 48-bit work arithmetic helpers.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int MAX_DIM = 4;
  localparam int WORK_W  = 48;
  localparam int SOL_W   = 32;
  localparam int IDX_W   = $clog2(MAX_DIM);

  typedef logic signed [WORK_W-1:0] work_t;

  // divider request controls from sequencer to shared divider
  typedef struct packed {
    logic        start;
    logic        sol;      // 1: saturate to 32 bits, 0: to 48 bits
  } div_ctl_t;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_COPY   = 4'd1;
  localparam logic [3:0] S_PIVOT  = 4'd2;
  localparam logic [3:0] S_SWAP   = 4'd3;
  localparam logic [3:0] S_FACT   = 4'd4;
  localparam logic [3:0] S_ELIM   = 4'd6;
  localparam logic [3:0] S_DIAG   = 4'd7;
  localparam logic [3:0] S_DDONE  = 4'd8;
  localparam logic [3:0] S_QWAIT  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // signed magnitude saturate to -cap..cap-1, cap 2^31 (sol) or 2^47
  function automatic work_t sat_mag(input logic [63:0] q, input logic neg,
                                    input logic sol);
    logic [63:0] cap;
    logic [63:0] m;
    begin
      cap = sol ? 64'h8000_0000 : 64'h8000_0000_0000;
      m = q;
      if (neg) begin
        if (m >= cap) m = cap;
        m = -m;
      end else if (m >= cap) begin
        m = cap - 64'd1;
      end
      sat_mag = m[WORK_W-1:0];
    end
  endfunction

  function automatic work_t sub_sat(input work_t a, input work_t b);
    logic signed [WORK_W:0] d;
    begin
      d = {a[WORK_W-1], a} - {b[WORK_W-1], b};
      if (d[WORK_W] != d[WORK_W-1])
        sub_sat = d[WORK_W] ? {1'b1, {(WORK_W-1){1'b0}}} : {1'b0, {(WORK_W-1){1'b1}}};
      else
        sub_sat = d[WORK_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/cls_stream_if.sv
// ----------------------------------------------------------------------------
// cls_stream_if: valid/ready channel carrying a payload
// A word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cls_stream_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/cramer_linear_solver_unit.sv
// ----------------------------------------------------------------------------
// cramer_linear_solver_unit: 4x4 Cramer's-rule linear system solver
// Loads matrix then right-hand side, solves by elimination determinants.
// ----------------------------------------------------------------------------
// Usage: words arrive on in_ (coeff, signed Q16.16): dim*dim matrix entries
// row by row, then dim right-hand-side entries. While in_ready is high words
// may arrive back to back. After the last word in_ready drops while one
// shared multiplier and one shared bit-serial divider compute up to dim+1
// determinants by Gaussian elimination and dim quotients. Results go out on
// out_ one word per unknown, last on the final one, or a single singular
// word. A held result stalls the sequencer, before its next quotient or
// before loading, until taken. cfg_we writes dim (applied 1..MAX_DIM) and
// restarts loading; write only while idle. Reset (rst_n low, synchronous)
// sets dim to 4 and empties the load count; stored matrix data are undefined
// until loaded.
// ----------------------------------------------------------------------------
module cramer_linear_solver_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  cls_stream_if.sink   in_ch,
  cls_stream_if.source out_ch
);
  import cls_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM);
  localparam int SQ = MAX_DIM * MAX_DIM;

  logic [2:0]    dim_r;
  logic [DW-1:0] n;
  logic [7:0]    load_r;
  logic [AW-1:0] lr_r, lc_r;
  logic [3:0]    st_r;
  logic signed [31:0] mat_r [SQ];
  logic signed [31:0] rhs_r [MAX_DIM];
  work_t         wk_r [SQ];
  logic [AW-1:0] i_r, j_r, k_r;
  logic [DW:0]   col_r;     // MAX_DIM means main determinant pass
  logic          flip_r;
  work_t         det_r, main_r, f_r;
  logic          mstart_r, dstart_r, dsol_r, mdiag_r;
  logic          mdone, ddone;
  work_t         mp, dq;
  work_t         ma, mb, dn, dd;
  div_ctl_t      dctl;
  logic          ov_r;
  logic [35:0]   od_r;
  logic [7:0]    sqn;

  // row-major slot of entry (r, c)
  function automatic logic [2*AW-1:0] widx(input logic [AW-1:0] r, input logic [AW-1:0] c);
    return {r, c};
  endfunction

  always_comb begin
    if (dim_r == 3'd0) n = DW'(1);
    else if (32'(dim_r) > MAX_DIM) n = DW'(MAX_DIM);
    else n = DW'(dim_r);
  end
  assign sqn = 8'(n) * 8'(n);

  cls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk, .rst_n, .start(mstart_r), .a(ma), .b(mb), .done(mdone), .p(mp));
  assign dctl.start = dstart_r;
  assign dctl.sol   = dsol_r;
  cls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .ctl(dctl), .n(dn), .d(dd), .done(ddone), .q(dq));

  assign ma = mdiag_r ? det_r : wk_r[widx(i_r, k_r)];
  assign mb = mdiag_r ? wk_r[widx(k_r, k_r)] : f_r;
  assign dn = dsol_r ? det_r : wk_r[widx(j_r, i_r)];
  assign dd = dsol_r ? main_r : wk_r[widx(i_r, i_r)];

  assign in_ch.ready  = (st_r == S_LOAD) && !cfg_we;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 3'd4;
      load_r <= '0;
      lr_r <= '0;
      lc_r <= '0;
      st_r <= S_LOAD;
      ov_r <= 1'b0;
      mstart_r <= 1'b0;
      dstart_r <= 1'b0;
      main_r <= '0;
    end else begin
      mstart_r <= 1'b0;
      dstart_r <= 1'b0;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      if (cfg_we) begin
        dim_r <= cfg_wdata;
        load_r <= '0;
        lr_r <= '0;
        lc_r <= '0;
      end
      case (st_r)
        S_LOAD: if (in_ch.valid && !cfg_we) begin
          if (load_r < sqn) begin
            mat_r[widx(lr_r, lc_r)] <= in_ch.data[31:0];
            if (32'(lc_r) + 1 >= 32'(n)) begin
              lc_r <= '0;
              lr_r <= lr_r + AW'(1);
            end else lc_r <= lc_r + AW'(1);
          end else
            rhs_r[AW'(load_r - sqn)] <= in_ch.data[31:0];
          if (load_r + 8'd1 >= sqn + 8'(n)) begin
            load_r <= '0;
            lr_r <= '0;
            lc_r <= '0;
            col_r <= (DW+1)'(MAX_DIM);
            st_r <= S_COPY;
          end else load_r <= load_r + 8'd1;
        end
        S_COPY: begin
          for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
              wk_r[widx(AW'(r), AW'(c))] <= (32'(col_r) == c)
                ? {{16{rhs_r[AW'(r)][31]}}, rhs_r[AW'(r)]}
                : {{16{mat_r[widx(AW'(r), AW'(c))][31]}}, mat_r[widx(AW'(r), AW'(c))]};
          i_r <= '0; flip_r <= 1'b0;
          st_r <= S_PIVOT;
        end
        S_PIVOT: begin
          if (wk_r[widx(i_r, i_r)] != '0) begin
            j_r <= i_r + AW'(1);
            if (32'(i_r) + 1 >= 32'(n)) begin
              det_r <= work_t'(1) << FRAC_BITS; k_r <= '0; mdiag_r <= 1'b1;
              mstart_r <= 1'b1; st_r <= S_DIAG;
            end else begin
              dsol_r <= 1'b0; dstart_r <= 1'b1; st_r <= S_FACT;
            end
          end else begin
            j_r <= i_r + AW'(1);
            st_r <= S_SWAP;
          end
        end
        S_SWAP: begin
          if (32'(i_r) + 1 >= 32'(n) || 32'(j_r) >= 32'(n) || j_r == '0) begin
            det_r <= '0; st_r <= S_DDONE;
          end else if (wk_r[widx(j_r, i_r)] != '0) begin
            for (int c = 0; c < MAX_DIM; c++) begin
              wk_r[widx(i_r, AW'(c))] <= wk_r[widx(j_r, AW'(c))];
              wk_r[widx(j_r, AW'(c))] <= wk_r[widx(i_r, AW'(c))];
            end
            flip_r <= ~flip_r; st_r <= S_PIVOT;
          end else if (32'(j_r) + 1 >= 32'(n)) begin
            det_r <= '0; st_r <= S_DDONE;
          end else j_r <= j_r + AW'(1);
        end
        S_FACT: if (ddone) begin
          f_r <= dq; k_r <= i_r; mdiag_r <= 1'b0; mstart_r <= 1'b1; st_r <= S_ELIM;
        end
        S_ELIM: if (mdone) begin
          wk_r[widx(j_r, k_r)] <= sub_sat(wk_r[widx(j_r, k_r)], mp);
          if (32'(k_r) + 1 < 32'(n)) begin
            k_r <= k_r + AW'(1); mstart_r <= 1'b1;
          end else if (32'(j_r) + 1 < 32'(n)) begin
            j_r <= j_r + AW'(1); dstart_r <= 1'b1; st_r <= S_FACT;
          end else begin
            i_r <= i_r + AW'(1); st_r <= S_PIVOT;
          end
        end
        S_DIAG: if (mdone) begin
          if (32'(k_r) + 1 < 32'(n)) begin
            det_r <= mp;
            k_r <= k_r + AW'(1); mstart_r <= 1'b1;
          end else begin
            det_r <= flip_r ? sub_sat('0, mp) : mp;
            st_r <= S_DDONE;
          end
        end
        S_DDONE: begin
          if (32'(col_r) == MAX_DIM) begin
            main_r <= det_r;
            if (det_r == '0) begin
              od_r <= {32'd0, 2'd0, 1'b1, 1'b1}; ov_r <= 1'b1; st_r <= S_OUT;
            end else begin
              col_r <= '0; st_r <= S_COPY;
            end
          end else if (!ov_r) begin
            // quotient only starts once the previous word has left
            dsol_r <= 1'b1; dstart_r <= 1'b1; st_r <= S_QWAIT;
          end
        end
        S_QWAIT: if (ddone) begin
          od_r <= {dq[31:0], IDX_W'(col_r), 1'b0, (32'(col_r) + 1 == 32'(n))};
          ov_r <= 1'b1;
          if (32'(col_r) + 1 == 32'(n)) st_r <= S_OUT;
          else begin col_r <= col_r + 1'b1; st_r <= S_COPY; end
        end
        S_OUT: if (!ov_r || out_ch.ready) st_r <= S_LOAD;
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule

FILE: rtl/core/cls_mul.sv
// ----------------------------------------------------------------------------
// cls_mul: shared saturating fixed-point multiplier
// Four 24x24 partial products in turn, then shift and saturate.
// ----------------------------------------------------------------------------
module cls_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cls_pkg::work_t       a,
  input  cls_pkg::work_t       b,
  output logic                 done,
  output cls_pkg::work_t       p
);
  import cls_pkg::*;

  logic [2:0]  step_r;
  logic        busy_r;
  logic [47:0] ua_r, ub_r;
  logic        neg_r;
  logic [47:0] pp_r;
  logic [63:0] p0_r, p1_r, p2_r;
  logic [23:0] x, y;
  logic        ovf;
  logic [63:0] q;

  always_comb begin
    case (step_r)
      3'd0:    begin x = ua_r[23:0];  y = ub_r[23:0];  end
      3'd1:    begin x = ua_r[47:24]; y = ub_r[23:0];  end
      3'd2:    begin x = ua_r[23:0];  y = ub_r[47:24]; end
      default: begin x = ua_r[47:24]; y = ub_r[47:24]; end
    endcase
  end

  always_ff @(posedge clk) begin
    pp_r <= x * y;
  end

  assign ovf = (p2_r >= (64'd1 << (FRAC_BITS - 1))) || (p1_r >= (64'd1 << (23 + FRAC_BITS)));
  assign q = ovf ? (64'd1 << 47)
               : ((p2_r << (48 - FRAC_BITS)) + (p1_r << (24 - FRAC_BITS)) + (p0_r >> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
        ua_r   <= a[47] ? 48'(-a) : a;
        ub_r   <= b[47] ? 48'(-b) : b;
        neg_r  <= a[47] ^ b[47];
        p1_r   <= 64'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        case (step_r)
          3'd1: p0_r <= {16'd0, pp_r};
          3'd2: p1_r <= {16'd0, pp_r};
          3'd3: p1_r <= p1_r + {16'd0, pp_r};
          3'd4: p2_r <= {16'd0, pp_r};
          3'd5: begin
            p <= sat_mag(q, neg_r, 1'b0);
            done <= 1'b1;
            busy_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: rtl/core/cls_div.sv
// ----------------------------------------------------------------------------
// cls_div: shared restoring divider, one quotient bit per cycle
// Quotient (n << FRAC_BITS) / d toward zero, saturated to 48 or 32 bits; 0 if d is 0.
// ----------------------------------------------------------------------------
module cls_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cls_pkg::div_ctl_t ctl,
  input  cls_pkg::work_t    n,
  input  cls_pkg::work_t    d,
  output logic              done,
  output cls_pkg::work_t    q
);
  import cls_pkg::*;

  localparam int TOT = 48 + FRAC_BITS;

  logic [6:0]     cnt_r;
  logic           busy_r, neg_r, sol_r;
  logic [TOT-1:0] num_r;
  logic [TOT-1:0] quo_r;
  logic [47:0]    rem_r;
  logic [47:0]    ud_r;
  logic [48:0]    trial;
  logic [63:0]    capq;

  assign trial = {rem_r[47:0], num_r[TOT-1]};
  assign capq  = (sol_r ? 64'h8000_0000 : 64'h8000_0000_0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        neg_r  <= n[47] ^ d[47];
        sol_r  <= ctl.sol;
        num_r  <= {(n[47] ? 48'(-n) : n), {FRAC_BITS{1'b0}}};
        ud_r   <= d[47] ? 48'(-d) : d;
        rem_r  <= 48'd0;
        quo_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 7'(TOT)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          if (ud_r == 48'd0)
            q <= '0;
          else if (quo_r >= TOT'(capq))
            q <= sat_mag(capq, neg_r, sol_r);
          else
            q <= sat_mag({16'd0, quo_r[47:0]}, neg_r, sol_r);
        end else begin
          cnt_r <= cnt_r + 7'd1;
          num_r <= num_r << 1;
          if (trial >= {1'b0, ud_r}) begin
            rem_r <= 48'(trial - {1'b0, ud_r});
            quo_r <= {quo_r[TOT-2:0], 1'b1};
          end else begin
            rem_r <= trial[47:0];
            quo_r <= {quo_r[TOT-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cramer_linear_solver_unit
// Loads matrices and right-hand sides, predicts each solution word with a
// local fixed-point solver and checks every result word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import cls_pkg::*;

  localparam int MAXD     = 4;
  localparam int FRAC     = 16;
  localparam int STALL_LIM = 60000;

  typedef struct {
    logic [31:0] solution;
    logic [1:0]  unknown_index;
    logic        singular;
    logic        last;
  } sol_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;

  cls_stream_if #(.W(32)) in_ch();
  cls_stream_if #(.W(36)) out_ch();

  cramer_linear_solver_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // solver copy of the block state
  longint    mat_q[MAXD*MAXD];
  longint    rhs_q[MAXD];
  longint    wrk_q[MAXD*MAXD];
  int        loaded_words;
  logic [2:0] dim_reg;

  sol_word_t pending_solutions[$];
  longint    word_list[$];
  int        errors = 0;
  int        systems_solved = 0;
  int        singular_seen = 0;
  int        results_seen = 0;
  bit        no_idle = 1'b0;
  int        stall_cnt = 0;

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat_signed(logic [63:0] q, bit neg, int bits);
    logic [63:0] cap;
    cap = 64'd1 << bits;
    if (neg) begin
      if (q >= cap) q = cap;
      return -longint'(q);
    end
    if (q >= cap) q = cap - 64'd1;
    return longint'(q);
  endfunction

  function automatic longint clamp_work(longint v);
    return sat_signed(magnitude(v), v < 0, 47);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] ua, ub, ah, al, bh, bl, p0, p1, p2, q;
    ua = magnitude(a);
    ub = magnitude(b);
    ah = ua >> 24; al = ua & 64'hFF_FFFF;
    bh = ub >> 24; bl = ub & 64'hFF_FFFF;
    p0 = al * bl;
    p1 = ah * bl + al * bh;
    p2 = ah * bh;
    if (p2 >= (64'd1 << (FRAC-1)) || p1 >= (64'd1 << (23+FRAC)))
      q = 64'd1 << 47;
    else
      q = (p2 << (48-FRAC)) + (p1 << (24-FRAC)) + (p0 >> FRAC);
    return sat_signed(q, (a < 0) != (b < 0), 47);
  endfunction

  function automatic longint fx_div(longint n, longint d, int bits);
    logic [63:0] un, ud, q, r, cap;
    bit neg;
    if (d == 0) return 0;
    un = magnitude(n);
    ud = magnitude(d);
    neg = (n < 0) != (d < 0);
    cap = 64'd1 << bits;
    q = un / ud;
    r = un % ud;
    if (q >= (cap >> FRAC)) return sat_signed(cap, neg, bits);
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 64'd1;
      end
    end
    return sat_signed(q, neg, bits);
  endfunction

  // elimination determinant of the n-by-n work copy, swap on zero pivot
  function automatic longint work_determinant(int n);
    bit flip;
    longint det, f, t;
    int r;
    flip = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (wrk_q[i*MAXD+i] == 0) begin
        r = -1;
        for (int j = i + 1; j < n; j++)
          if (r < 0 && wrk_q[j*MAXD+i] != 0) r = j;
        if (r < 0) return 0;
        for (int k = 0; k < n; k++) begin
          t = wrk_q[i*MAXD+k];
          wrk_q[i*MAXD+k] = wrk_q[r*MAXD+k];
          wrk_q[r*MAXD+k] = t;
        end
        flip = !flip;
      end
      for (int j = i + 1; j < n; j++) begin
        f = fx_div(wrk_q[j*MAXD+i], wrk_q[i*MAXD+i], 47);
        for (int k = i; k < n; k++)
          wrk_q[j*MAXD+k] = clamp_work(wrk_q[j*MAXD+k] - fx_mul(wrk_q[i*MAXD+k], f));
      end
    end
    det = longint'(1) << FRAC;
    for (int i = 0; i < n; i++) det = fx_mul(det, wrk_q[i*MAXD+i]);
    if (flip) det = clamp_work(-det);
    return det;
  endfunction

  function automatic void fill_work(int n, int col);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        wrk_q[i*MAXD+j] = (j == col) ? rhs_q[i] : mat_q[i*MAXD+j];
  endfunction

  function automatic int active_dim();
    if (dim_reg == 3'd0) return 1;
    if (dim_reg > 3'(MAXD)) return MAXD;
    return int'(dim_reg);
  endfunction

  // takes one accepted word, queues the solution words it completes
  function automatic void solve_on_word(logic [31:0] raw);
    int n, sq, idx;
    longint v, main_det, x;
    sol_word_t w;
    n = active_dim();
    sq = n * n;
    v = longint'($signed(raw));
    idx = loaded_words;
    if (idx >= sq + n) idx = 0;
    if (idx < sq) mat_q[(idx / n) * MAXD + idx % n] = v;
    else rhs_q[idx - sq] = v;
    idx++;
    if (idx < sq + n) begin
      loaded_words = idx;
      return;
    end
    loaded_words = 0;
    systems_solved++;
    fill_work(n, -1);
    main_det = work_determinant(n);
    if (main_det == 0) begin
      w.solution = '0; w.unknown_index = '0; w.singular = 1'b1; w.last = 1'b1;
      pending_solutions.push_back(w);
      singular_seen++;
      return;
    end
    for (int c = 0; c < n; c++) begin
      fill_work(n, c);
      x = fx_div(work_determinant(n), main_det, 31);
      w.solution = x[31:0];
      w.unknown_index = c[1:0];
      w.singular = 1'b0;
      w.last = (c == n - 1);
      pending_solutions.push_back(w);
    end
  endfunction

  // result checker and receiver stalls
  always @(negedge clk)
    out_ch.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 31);

  always @(posedge clk) begin
    sol_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_solutions.size() == 0) begin
        $error("unexpected result word %h", out_ch.data);
        errors++;
      end else begin
        e = pending_solutions.pop_front();
        if (out_ch.data[35:4] !== e.solution) begin
          $error("solution expected %h actual %h", e.solution, out_ch.data[35:4]);
          errors++;
        end
        if (out_ch.data[3:2] !== e.unknown_index) begin
          $error("unknown_index expected %0d actual %0d", e.unknown_index, out_ch.data[3:2]);
          errors++;
        end
        if (out_ch.data[1] !== e.singular) begin
          $error("singular expected %b actual %b", e.singular, out_ch.data[1]);
          errors++;
        end
        if (out_ch.data[0] !== e.last) begin
          $error("last expected %b actual %b", e.last, out_ch.data[0]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIM) begin
      $display("timeout after %0d idle cycles", stall_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(longint v);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= v[31:0];
    do @(posedge clk); while (!in_ch.ready);
    solve_on_word(v[31:0]);
    @(negedge clk);
  endtask

  task automatic send_list();
    while (word_list.size() > 0) send_word(word_list.pop_front());
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_solutions.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_dim(logic [2:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    dim_reg = d;
    loaded_words = 0;
  endtask

  function automatic longint q16(int whole);
    return longint'(whole) <<< FRAC;
  endfunction

  function automatic longint rand_coeff(int kind);
    case (kind)
      0: return longint'($signed($urandom_range(0, 32'h000F_FFFF))) - 64'sh8_0000;
      1: return longint'($signed($urandom()));
      default: return ($urandom_range(0, 3) == 0) ? 0 : q16($urandom_range(0, 8)) - q16(4);
    endcase
  endfunction

  // matrix plus rhs for n unknowns; kind 3 copies a row to force singularity
  task automatic queue_system(int n, int kind);
    longint m[MAXD*MAXD];
    int src;
    for (int i = 0; i < n * n; i++) m[i] = rand_coeff(kind == 3 ? 0 : kind);
    if (kind == 0)
      for (int i = 0; i < n; i++) m[i*n+i] = m[i*n+i] + q16(6);
    if (kind == 3 && n > 1) begin
      src = $urandom_range(0, n - 2);
      for (int j = 0; j < n; j++) m[(n-1)*n+j] = m[src*n+j];
    end
    for (int i = 0; i < n * n; i++) word_list.push_back(m[i]);
    for (int i = 0; i < n; i++) word_list.push_back(rand_coeff(kind == 3 ? 0 : kind));
  endtask

  task automatic test_dim_extremes();
    write_dim(3'd1);
    word_list = '{q16(2), q16(3)};
    send_list();
    word_list = '{0, q16(5)};
    send_list();
    word_list = '{32'sh7FFF_FFFF, -64'sh8000_0000};
    send_list();
    write_dim(3'd0);   // acts as one
    word_list = '{-64'sh8000_0000, 64'sh7FFF_FFFF};
    send_list();
    write_dim(3'd7);   // acts as four
    queue_system(4, 0);
    send_list();
  endtask

  task automatic test_pivot_and_singular();
    write_dim(3'd2);
    // zero pivot, lower row swapped in
    word_list = '{0, q16(1), q16(2), q16(1), q16(3), q16(4)};
    send_list();
    // zero column, singular
    word_list = '{0, q16(1), 0, q16(2), q16(1), q16(1)};
    send_list();
    write_dim(3'd3);
    queue_system(3, 3);
    send_list();
    write_dim(3'd4);
    // identity scaled by the largest word
    for (int i = 0; i < 16; i++) word_list.push_back((i % 5 == 0) ? 64'sh7FFF_FFFF : 0);
    for (int i = 0; i < 4; i++) word_list.push_back(-64'sh8000_0000);
    send_list();
  endtask

  task automatic test_midload_restart();
    write_dim(3'd3);
    word_list = '{q16(1), q16(2), q16(3), q16(4)};
    send_list();
    write_dim(3'd2);   // partial load discarded
    queue_system(2, 0);
    send_list();
  endtask

  task automatic test_random_systems();
    int words, n, kind;
    words = 0;
    while (words < 480) begin
      no_idle = (words >= 160 && words < 240);
      n = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
      kind = $urandom_range(0, 9);
      kind = (kind < 6) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
      write_dim(3'(n));
      if ($urandom_range(0, 15) == 0) begin
        // broken load, then restart with a fresh write
        for (int i = 0; i < n; i++) word_list.push_back(rand_coeff(1));
        words += n;
        send_list();
        write_dim(3'(n));
      end
      queue_system(n, kind);
      words += word_list.size();
      send_list();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    dim_reg = 3'd4;
    loaded_words = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_dim_extremes();
    test_pivot_and_singular();
    test_midload_restart();
    test_random_systems();
    drain();
    repeat (200) @(negedge clk);
    $display("solved %0d systems (%0d singular), %0d result words checked",
             systems_solved, singular_seen, results_seen);
    $display("orders 1 to 4, zero pivots, restarts, saturated and full-range words");
    if (errors == 0 && pending_solutions.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
